>>> sv/sbspp_pkg.sv
// Package for the servo bus status packet parser: codes, widths and result layout.
package sbspp_pkg;

	localparam int BYTE_W   = 8;
	localparam int POS_W    = 9;
	localparam int STATUS_W = 3;
	localparam int TDATA_W  = 40;

	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;
	localparam logic [BYTE_W-1:0] MIN_LEN  = 8'd2;

	// Byte positions inside a packet; parameters start at POS_PARAM
	localparam logic [POS_W-1:0] POS_HDR0  = 9'd0;
	localparam logic [POS_W-1:0] POS_HDR1  = 9'd1;
	localparam logic [POS_W-1:0] POS_ID    = 9'd2;
	localparam logic [POS_W-1:0] POS_LEN   = 9'd3;
	localparam logic [POS_W-1:0] POS_ERR   = 9'd4;
	localparam logic [POS_W-1:0] POS_PARAM = 9'd5;

	// Device error byte bit positions
	localparam int ERR_VOLTAGE  = 0;
	localparam int ERR_OVERHEAT = 2;
	localparam int ERR_CHECKSUM = 4;
	localparam int ERR_OVERLOAD = 5;
	localparam int ERR_INSTR    = 6;

	// Result kinds carried on tuser
	localparam logic KIND_PARAM  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_BAD_HEADER = 3'd1,
		ST_BAD_LENGTH = 3'd2,
		ST_DEV_CSUM   = 3'd3,
		ST_DEV_INSTR  = 3'd4,
		ST_CSUM_FAIL  = 3'd5
	} status_t;

	// Result payload, first field in the highest bits
	typedef struct packed {
		logic [1:0]        pad;
		logic [BYTE_W-1:0] device_error;
		logic              overload_flag;
		logic              overheat_flag;
		logic              voltage_flag;
		status_t           status;
		logic [BYTE_W-1:0] source_id;
		logic [BYTE_W-1:0] param_index;
		logic [BYTE_W-1:0] param_value;
	} result_t;

endpackage

>>> sv/servo_bus_status_packet_parser_unit.sv
// Top level of the servo bus status packet parser.
//
// Input channel s_axis carries one received serial byte per item in tdata.
// Output channel m_axis carries results: tuser is 0 for a parameter byte and
// 1 for the final status of a packet. A packet is FF FF, id, length, device
// error byte, length-2 parameters and an inverted 8-bit sum checksum. Every
// parameter byte gives a result as it arrives; the checksum byte, a bad header
// byte or a length below 2 gives one status result, after which the parser
// waits for a new header. Header, id, length and error bytes give no result.
//
// An accepted byte is held in the input register, is decoded against the
// parse state and lands in the output register. One byte can be accepted
// every cycle while no result-giving byte waits on a stalled output; the
// parse state update (an 8-bit add and compare) loops through the parse
// state registers. When the receiver stalls the output register holds its
// item; bytes that give no result still drain, and s_axis_tready drops only
// when a byte that gives a result meets a full, stalled output register.
// Reset clears the parse state and both valid flags.
module servo_bus_status_packet_parser_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [sbspp_pkg::BYTE_W-1:0] s_axis_tdata,  // rx_byte[7:0]
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// param_value[7:0], param_index[15:8], source_id[23:16], status[26:24],
	// voltage_flag[27], overheat_flag[28], overload_flag[29],
	// device_error[37:30], zero[39:38]
	output logic [sbspp_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                        m_axis_tuser   // result_kind[0]
);
	import sbspp_pkg::*;

	// Input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Parse state
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] id_q;
	logic [BYTE_W-1:0] count_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] err_q;

	logic [POS_W-1:0]  pos_d;
	logic [BYTE_W-1:0] id_d;
	logic [BYTE_W-1:0] count_d;
	logic [BYTE_W-1:0] sum_d;
	logic [BYTE_W-1:0] err_d;

	// Output register
	logic    out_valid_q;
	logic    out_kind_q;
	result_t out_q;

	logic    res_has;
	logic    res_kind;
	result_t res;
	logic    advance;
	logic [POS_W-1:0]  param_k;
	logic [BYTE_W-1:0] sum_add;
	logic    finish;

	assign param_k = pos_q - POS_PARAM;
	assign sum_add = sum_q + byte_s1;

	// Decode the held byte against the parse state
	always_comb begin
		pos_d    = pos_q;
		id_d     = id_q;
		count_d  = count_q;
		sum_d    = sum_q;
		err_d    = err_q;
		res_has  = 1'b0;
		res_kind = KIND_STATUS;
		finish   = 1'b0;
		res              = '0;
		res.source_id    = id_q;
		res.device_error = err_q;
		case (pos_q)
			POS_HDR0, POS_HDR1: begin
				if (byte_s1 != HDR_BYTE) begin
					finish     = 1'b1;
					res.status = ST_BAD_HEADER;
				end else begin
					pos_d = pos_q + 1'b1;
				end
			end
			POS_ID: begin
				id_d  = byte_s1;
				sum_d = byte_s1;
				pos_d = POS_LEN;
			end
			POS_LEN: begin
				if (byte_s1 < MIN_LEN) begin
					finish     = 1'b1;
					res.status = ST_BAD_LENGTH;
				end else begin
					count_d = byte_s1 - MIN_LEN;
					sum_d   = sum_add;
					pos_d   = POS_ERR;
				end
			end
			POS_ERR: begin
				err_d = byte_s1;
				sum_d = sum_add;
				pos_d = POS_PARAM;
			end
			default: begin
				if (param_k < {1'b0, count_q}) begin
					// parameter byte
					sum_d           = sum_add;
					pos_d           = pos_q + 1'b1;
					res_has         = 1'b1;
					res_kind        = KIND_PARAM;
					res.param_value = byte_s1;
					res.param_index = param_k[BYTE_W-1:0];
				end else begin
					// checksum byte
					finish = 1'b1;
					if (~sum_q != byte_s1) begin
						res.status = ST_CSUM_FAIL;
					end else if (err_q[ERR_CHECKSUM]) begin
						res.status = ST_DEV_CSUM;
					end else if (err_q[ERR_INSTR]) begin
						res.status = ST_DEV_INSTR;
					end else begin
						res.status        = ST_OK;
						res.voltage_flag  = err_q[ERR_VOLTAGE];
						res.overheat_flag = err_q[ERR_OVERHEAT];
						res.overload_flag = err_q[ERR_OVERLOAD];
					end
				end
			end
		endcase
		if (finish) begin
			res_has = 1'b1;
			pos_d   = POS_HDR0;
			id_d    = '0;
			count_d = '0;
			sum_d   = '0;
			err_d   = '0;
		end
	end

	// Held byte moves on when it needs no slot or the slot frees up
	assign advance       = valid_s1 && (!res_has || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_HDR0;
			id_q    <= '0;
			count_q <= '0;
			sum_q   <= '0;
			err_q   <= '0;
		end else if (advance) begin
			pos_q   <= pos_d;
			id_q    <= id_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			err_q   <= err_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_has) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_has) begin
			out_kind_q <= res_kind;
			out_q      <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = out_q;

endmodule

>>> sv/sbspp_checker.sv
// Port-level checker for the servo bus status packet parser, bound to the top level.
module sbspp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [sbspp_pkg::TDATA_W-1:0]  m_axis_tdata,
	input logic                          m_axis_tuser
);
	import sbspp_pkg::*;

	result_t r;
	assign r = m_axis_tdata;

	// A stalled result item holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result item changed");

	// Parameter items carry no status and no flags
	a_param: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_PARAM |->
			r.status == ST_OK && !r.voltage_flag && !r.overheat_flag && !r.overload_flag)
		else $error("parameter item with status or flags");

	// Flags appear only with ok status, and only as the device reported them
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_STATUS && r.status != ST_OK |->
			!r.voltage_flag && !r.overheat_flag && !r.overload_flag)
		else $error("flags set on a failed packet");

	a_flag_src: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_STATUS && r.status == ST_OK |->
			r.voltage_flag == r.device_error[ERR_VOLTAGE] &&
			r.overheat_flag == r.device_error[ERR_OVERHEAT] &&
			r.overload_flag == r.device_error[ERR_OVERLOAD] &&
			!r.device_error[ERR_CHECKSUM] && !r.device_error[ERR_INSTR])
		else $error("ok status does not match device error byte");

	// Status code stays within the defined set and padding stays zero
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> r.status <= ST_CSUM_FAIL && r.pad == 2'b00)
		else $error("undefined status code or nonzero padding");

endmodule

bind servo_bus_status_packet_parser_unit sbspp_checker u_sbspp_checker (.*);
